// ----- rtl/core/bkl_pkg.sv -----
// ----------------------------------------------------------------------------
// bkl_pkg
// Shared types, constants and character-class functions for the bracket and
// keyword lexer.
// ----------------------------------------------------------------------------
package bkl_pkg;

   localparam int unsigned MaxInputBytes = 65536;
   localparam int unsigned PosCapInt =
      (MaxInputBytes - 1 < 65535) ? MaxInputBytes - 1 : 65535;
   localparam int unsigned LenCapInt =
      (MaxInputBytes < 65535) ? MaxInputBytes : 65535;
   localparam logic [15:0] PosCap = 16'(PosCapInt);
   localparam logic [15:0] LenCap = 16'(LenCapInt);

   localparam logic [3:0] KindKeyword = 4'd7;
   localparam logic [3:0] KindWord    = 4'd8;

   // Match progress through "struct": 0..6 bytes matched, or no match possible.
   localparam logic [2:0] KwFirst = 3'd1;
   localparam logic [2:0] KwLen   = 3'd6;
   localparam logic [2:0] KwDead  = 3'd7;

   localparam logic [7:0] CharLowS = 8'h73;

   localparam int unsigned QueueDepth    = 4;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic        last_result;
   } token_type;

   // Up to two tokens produced by one request, packed from the first slot.
   typedef struct packed {
      logic      first_valid;
      logic      second_valid;
      token_type first;
      token_type second;
   } push_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] index;
   } punct_type;

   function automatic logic is_word_char(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A) || (b == 8'h5F);
   endfunction

   function automatic logic is_separator(input logic [7:0] b);
      return (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h20);
   endfunction

   // Punctuators in kind order: { ( [ } ) ] ;
   function automatic punct_type punct_lookup(input logic [7:0] b);
      punct_type p;
      p.hit   = 1'b1;
      p.index = 3'd0;
      unique case (b)
         8'h7B: p.index = 3'd0;
         8'h28: p.index = 3'd1;
         8'h5B: p.index = 3'd2;
         8'h7D: p.index = 3'd3;
         8'h29: p.index = 3'd4;
         8'h5D: p.index = 3'd5;
         8'h3B: p.index = 3'd6;
         default: p.hit = 1'b0;
      endcase
      return p;
   endfunction

   // Expected byte of "struct" at a given match position.
   function automatic logic [7:0] kw_char(input logic [2:0] kp);
      logic [7:0] c;
      unique case (kp)
         3'd0:    c = 8'h73;
         3'd1:    c = 8'h74;
         3'd2:    c = 8'h72;
         3'd3:    c = 8'h75;
         3'd4:    c = 8'h63;
         3'd5:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic token_type word_token(input logic [2:0]  kp,
                                            input logic [15:0] start,
                                            input logic [15:0] len);
      token_type t;
      t.token_kind   = (kp == KwLen) ? KindKeyword : KindWord;
      t.token_start  = start;
      t.token_length = len;
      t.last_result  = 1'b0;
      return t;
   endfunction

endpackage

// ----- rtl/core/bkl_if.sv -----
// ----------------------------------------------------------------------------
// bkl_req_if / bkl_rsp_if
// Valid/ready channels for source bytes and for emitted tokens.
// ----------------------------------------------------------------------------
interface bkl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface bkl_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic        last_result;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output last_result, input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input last_result, output ready);
endinterface

// ----- rtl/core/bkl_lex_core.sv -----
// ----------------------------------------------------------------------------
// bkl_lex_core
// Request register, word tracking state and the per-byte token decision.
// ----------------------------------------------------------------------------
module bkl_lex_core
   import bkl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   input  logic       space_ok,
   output push_type   push
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        eoi_ff;

   logic        pending_ff, pending_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] len_ff, len_in;
   logic [2:0]  kp_ff, kp_in;
   logic [15:0] pos_ff, pos_in;

   logic        advance;
   logic        accept;
   logic        wc;
   punct_type   punct;
   logic [15:0] len_inc;
   logic [2:0]  kp_adv;
   logic        old_valid, new_valid;
   token_type   old_tok, new_tok;

   assign advance   = in_valid_ff && space_ok;
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign wc      = is_word_char(in_byte_ff);
   assign punct   = punct_lookup(in_byte_ff);
   assign len_inc = (len_ff < LenCap) ? len_ff + 16'd1 : len_ff;
   assign kp_adv  = (kp_ff < KwLen && kw_char(kp_ff) == in_byte_ff) ? kp_ff + 3'd1 : KwDead;

   always_comb begin
      pending_in = pending_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      kp_in      = kp_ff;
      old_valid  = 1'b0;
      new_valid  = 1'b0;
      old_tok    = word_token(kp_ff, start_ff, len_ff);
      new_tok    = '0;

      if (pending_ff && wc) begin
         len_in = len_inc;
         kp_in  = kp_adv;
         if (eoi_ff) begin
            new_valid = 1'b1;
            new_tok   = word_token(kp_adv, start_ff, len_inc);
         end
      end else begin
         // Any other byte closes the open word before its own token.
         old_valid  = pending_ff;
         pending_in = 1'b0;
         if (is_separator(in_byte_ff)) begin
            new_valid = 1'b0;
         end else if (punct.hit) begin
            new_valid            = 1'b1;
            new_tok.token_kind   = {1'b0, punct.index};
            new_tok.token_start  = pos_ff;
            new_tok.token_length = 16'd1;
         end else begin
            pending_in = 1'b1;
            start_in   = pos_ff;
            len_in     = 16'd1;
            kp_in      = (in_byte_ff == CharLowS) ? KwFirst : KwDead;
            if (eoi_ff) begin
               new_valid = 1'b1;
               new_tok   = word_token(kp_in, pos_ff, 16'd1);
            end
         end
      end

      if (eoi_ff) begin
         pending_in = 1'b0;
         start_in   = '0;
         len_in     = '0;
         kp_in      = '0;
         pos_in     = '0;
      end else begin
         pos_in = (pos_ff < PosCap) ? pos_ff + 16'd1 : pos_ff;
      end
   end

   always_comb begin
      push = '0;
      if (old_valid) begin
         push.first_valid  = advance;
         push.first        = old_tok;
         push.second_valid = advance && new_valid;
         push.second       = new_tok;
         if (new_valid) begin
            push.second.last_result = 1'b1;
         end else begin
            push.first.last_result = 1'b1;
         end
      end else begin
         push.first_valid       = advance && new_valid;
         push.first             = new_tok;
         push.first.last_result = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pending_ff  <= 1'b0;
         start_ff    <= '0;
         len_ff      <= '0;
         kp_ff       <= '0;
         pos_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            pending_ff <= pending_in;
            start_ff   <= start_in;
            len_ff     <= len_in;
            kp_ff      <= kp_in;
            pos_ff     <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
         eoi_ff     <= req_end_of_input;
      end
   end

   a_push_needs_item: assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> in_valid_ff && space_ok)
      else $error("token pushed without a held request");

   a_eoi_clears: assert property (@(posedge clock) disable iff (reset)
      advance && eoi_ff |=> !pending_ff && pos_ff == '0)
      else $error("end of input did not clear word state");

endmodule

// ----- rtl/core/bkl_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// bkl_rsp_queue
// Small token queue: takes up to two tokens a cycle, hands out one a cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module bkl_rsp_queue
   import bkl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      space_ok,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output token_type rsp_token
);

   token_type                  mem [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]   count_ff, count_in;
   logic                       pop;
   logic [QueueCntWidth-1:0]   push_n;
   logic [QueuePtrWidth-1:0]   wr_ptr_next;

   assign space_ok  = count_ff <= QueueCntWidth'(QueueDepth - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_token = mem[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   assign push_n      = QueueCntWidth'(push.first_valid) + QueueCntWidth'(push.second_valid);
   assign wr_ptr_next = wr_ptr_ff + QueuePtrWidth'(1);
   assign wr_ptr_in   = wr_ptr_ff + QueuePtrWidth'(push_n);
   assign rd_ptr_in   = rd_ptr_ff + QueuePtrWidth'(pop);
   assign count_in    = count_ff + push_n - QueueCntWidth'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem[wr_ptr_next] <= push.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntWidth'(QueueDepth))
      else $error("token queue overflow");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid)
      else $error("second token pushed without first");

endmodule

// ----- rtl/core/bracket_keyword_lexer.sv -----
// ----------------------------------------------------------------------------
// bracket_keyword_lexer
// Streaming tokenizer for bracketed text with the struct keyword.
//
// The req_chan channel takes one source byte per request, with end_of_input
// set on the final byte of an input. The rsp_chan channel returns tokens:
// kind, start offset, length and a flag on the last token of its byte.
// Each byte yields zero, one or two tokens; the second appears when a
// punctuator, or a final non-word non-separator byte, closes an open word.
//
// A request passes through the request register and then into the token
// queue before its tokens can be read out.
// A new byte is taken every cycle while the queue has room for two more
// tokens; bytes that yield two tokens are limited by the single token read
// port, so the sustained rate is one token per cycle.
//
// Reset clears the word state and the byte offset to zero and empties the
// queue. When the receiver stalls, the four-entry queue builds up; once it
// holds more than two tokens it holds the request register, which drops
// req_chan.ready.
// ----------------------------------------------------------------------------
module bracket_keyword_lexer
   import bkl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   bkl_req_if.sink  req_chan,
   bkl_rsp_if.source rsp_chan
);

   push_type  push;
   logic      space_ok;
   token_type rsp_token;

   bkl_lex_core u_lex_core (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_in_byte      (req_chan.in_byte),
      .req_end_of_input (req_chan.end_of_input),
      .space_ok         (space_ok),
      .push             (push)
   );

   bkl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_token (rsp_token)
   );

   assign rsp_chan.token_kind   = rsp_token.token_kind;
   assign rsp_chan.token_start  = rsp_token.token_start;
   assign rsp_chan.token_length = rsp_token.token_length;
   assign rsp_chan.last_result  = rsp_token.last_result;

endmodule

// ----- tb/sv/tb_bracket_keyword_lexer.sv -----
// ----------------------------------------------------------------------------
// tb_bracket_keyword_lexer
// Self-checking bench for the streaming bracket and keyword tokenizer.
// A queue of source bytes feeds a clocked driver. Each accepted request runs
// through a local token predictor, and a clocked monitor compares every token
// with the oldest predicted one. The stimulus has a short directed part, one
// input holding a long word, and random text built from keywords, words,
// punctuators, separators and raw bytes. Both sides idle at random, with
// calm stretches in between.
// ----------------------------------------------------------------------------
module tb_bracket_keyword_lexer;
   timeunit 1ns;
   timeprecision 1ps;

   import bkl_pkg::*;

   localparam int unsigned HalfPeriod    = 6;
   localparam int unsigned ResetCycles   = 10;
   localparam int unsigned RandomItems   = 1050;
   localparam int unsigned LongWordBytes = 200;
   localparam int unsigned MaxIdle       = 40;
   localparam int unsigned DrainCycles   = 16;
   localparam int unsigned MaxReported   = 10;
   localparam int unsigned CycleLimit    = 1_000_000;

   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharTop   = 8'hFF;

   // Punctuators in kind order, so the position in the string is the kind.
   localparam string PunctText   = "{([})];";
   localparam string KeywordText = "struct";
   localparam string BlankText   = "\t\n\r ";
   localparam string IdentChars  =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_struct";

   typedef struct {
      logic [7:0] data;
      logic       last;
   } text_byte_t;

   logic clock = 1'b0;
   logic reset;

   bkl_req_if req_bus ();
   bkl_rsp_if rsp_bus ();

   bracket_keyword_lexer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #(HalfPeriod) clock = 1'b1;
      #(HalfPeriod) clock = 1'b0;
   end

   text_byte_t  pending_bytes[$];
   token_type   expected_tokens[$];

   int unsigned cycle_count    = 0;
   int unsigned bytes_sent     = 0;
   int unsigned inputs_done    = 0;
   int unsigned tokens_checked = 0;
   int unsigned keywords_seen  = 0;
   int unsigned mismatch_count = 0;

   // Tokenizer state as seen by the predictor.
   logic        word_open  = 1'b0;
   logic [15:0] word_first = '0;
   logic [15:0] word_bytes = '0;
   logic [2:0]  kw_matched = '0;
   logic [15:0] byte_pos   = '0;

   function automatic logic ident_char(input logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
             (b >= "a" && b <= "z") || (b == "_");
   endfunction

   function automatic logic blank_char(input logic [7:0] b);
      return (b == CharTab) || (b == CharLf) || (b == CharCr) || (b == CharSpace);
   endfunction

   function automatic int punct_slot(input logic [7:0] b);
      for (int i = 0; i < PunctText.len(); i++)
         if (PunctText[i] == b)
            return i;
      return -1;
   endfunction

   function automatic void push_token(input logic [3:0]  kind,
                                      input logic [15:0] first,
                                      input logic [15:0] len);
      token_type t;
      t.token_kind   = kind;
      t.token_start  = first;
      t.token_length = len;
      t.last_result  = 1'b0;
      expected_tokens.push_back(t);
   endfunction

   function automatic void close_word();
      push_token((kw_matched == KwLen) ? KindKeyword : KindWord, word_first, word_bytes);
      word_open = 1'b0;
   endfunction

   function automatic void predict_tokens(input logic [7:0] b, input logic eoi);
      int count_in;
      int slot;
      count_in = expected_tokens.size();
      if (word_open && ident_char(b)) begin
         if (word_bytes < LenCap)
            word_bytes = word_bytes + 16'd1;
         if (kw_matched < KwLen && b == KeywordText[kw_matched])
            kw_matched = kw_matched + 3'd1;
         else
            kw_matched = KwDead;
         if (eoi)
            close_word();
      end else begin
         if (word_open)
            close_word();
         slot = punct_slot(b);
         if (blank_char(b)) begin
            // A separator only closes the open word.
         end else if (slot >= 0) begin
            push_token(4'(slot), byte_pos, 16'd1);
         end else begin
            word_open  = 1'b1;
            word_first = byte_pos;
            word_bytes = 16'd1;
            kw_matched = (b == KeywordText[0]) ? KwFirst : KwDead;
            if (eoi)
               close_word();
         end
      end
      if (expected_tokens.size() > count_in)
         expected_tokens[expected_tokens.size() - 1].last_result = 1'b1;
      if (eoi) begin
         word_open  = 1'b0;
         word_first = '0;
         word_bytes = '0;
         kw_matched = '0;
         byte_pos   = '0;
      end else if (byte_pos < PosCap) begin
         byte_pos = byte_pos + 16'd1;
      end
   endfunction

   function automatic void push_byte(input logic [7:0] b, input logic eoi);
      text_byte_t item;
      item.data = b;
      item.last = eoi;
      pending_bytes.push_back(item);
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i], 1'b0);
   endfunction

   function automatic void mark_input_end();
      if (pending_bytes.size() != 0)
         pending_bytes[pending_bytes.size() - 1].last = 1'b1;
   endfunction

   // Mostly well-formed tokens; raw bytes supply the noise.
   function automatic void add_random_piece();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         push_text(KeywordText);
      end else if (pick < 30) begin
         len = $urandom_range(1, 5);
         push_text(KeywordText.substr(0, len - 1));
      end else if (pick < 50) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++)
            push_byte(IdentChars[$urandom_range(0, IdentChars.len() - 1)], 1'b0);
      end else if (pick < 70) begin
         push_byte(PunctText[$urandom_range(0, PunctText.len() - 1)], 1'b0);
      end else if (pick < 88) begin
         push_byte(BlankText[$urandom_range(0, BlankText.len() - 1)], 1'b0);
      end else begin
         push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 24) == 0)
         mark_input_end();
   endfunction

   function automatic void add_random_text(input int unsigned items);
      int unsigned mark;
      mark = pending_bytes.size();
      while (pending_bytes.size() - mark < items)
         add_random_piece();
   endfunction

   function automatic logic calm_phase();
      return ((cycle_count / 512) % 4) == 0;
   endfunction

   function automatic int unsigned idle_length();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(5, MaxIdle);
   endfunction

   // Request driver.
   logic        req_fire;
   text_byte_t  next_byte;
   int unsigned send_hold;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_hold     <= 0;
      end else begin
         req_fire = req_bus.valid && req_bus.ready;
         if (req_fire) begin
            predict_tokens(req_bus.in_byte, req_bus.end_of_input);
            bytes_sent++;
            if (req_bus.end_of_input)
               inputs_done++;
         end
         if (req_fire || !req_bus.valid) begin
            if (send_hold != 0) begin
               req_bus.valid <= 1'b0;
               send_hold     <= send_hold - 1;
            end else if (pending_bytes.size() != 0) begin
               next_byte            = pending_bytes.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.in_byte      <= next_byte.data;
               req_bus.end_of_input <= next_byte.last;
               send_hold <= (calm_phase() || $urandom_range(0, 1) == 0) ? 0 : idle_length();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Token monitor and receiver stalls.
   token_type   seen;
   token_type   wanted;
   int unsigned take_hold;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_hold     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.token_kind   = rsp_bus.token_kind;
            seen.token_start  = rsp_bus.token_start;
            seen.token_length = rsp_bus.token_length;
            seen.last_result  = rsp_bus.last_result;
            if (expected_tokens.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MaxReported)
                  $display("unexpected token: kind %0d start %0d length %0d last %0b",
                           seen.token_kind, seen.token_start, seen.token_length,
                           seen.last_result);
            end else begin
               wanted = expected_tokens.pop_front();
               tokens_checked++;
               if (wanted.token_kind == KindKeyword)
                  keywords_seen++;
               if (seen !== wanted) begin
                  mismatch_count++;
                  if (mismatch_count <= MaxReported) begin
                     $display("token %0d mismatch: expected kind %0d start %0d length %0d last %0b",
                              tokens_checked, wanted.token_kind, wanted.token_start,
                              wanted.token_length, wanted.last_result);
                     $display("   got kind %0d start %0d length %0d last %0b",
                              seen.token_kind, seen.token_start, seen.token_length,
                              seen.last_result);
                  end
               end
            end
         end
         if (take_hold != 0) begin
            rsp_bus.ready <= 1'b0;
            take_hold     <= take_hold - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!calm_phase() && $urandom_range(0, 99) < 30)
               take_hold <= idle_length();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles with %0d tokens outstanding",
                  cycle_count, expected_tokens.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.in_byte      = '0;
      req_bus.end_of_input = 1'b0;
      rsp_bus.ready        = 1'b0;

      // Keyword closed by a punctuator, then the remaining punctuators.
      push_text("struct{");
      push_text("([})];");
      // Partial keyword flushed as a word at end of input.
      push_text("st");
      push_byte("r", 1'b1);
      // NUL and a high byte each start a word; the second one is extended.
      push_byte(CharNul, 1'b0);
      push_byte(CharTop, 1'b0);
      push_text("_9");
      // Every separator, with the input ending on trailing whitespace.
      push_byte(CharTab, 1'b0);
      push_byte(CharLf, 1'b0);
      push_byte(CharCr, 1'b0);
      push_byte(CharSpace, 1'b1);

      add_random_text(RandomItems / 2);
      mark_input_end();

      // One input with a long word, then a punctuator and the keyword.
      for (int i = 0; i < LongWordBytes; i++)
         push_byte("a", 1'b0);
      push_text(";struct");
      push_byte(CharSpace, 1'b1);

      add_random_text(RandomItems - RandomItems / 2);
      mark_input_end();

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_bus.valid || expected_tokens.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("sent %0d bytes in %0d inputs, including one long-word input of %0d bytes",
               bytes_sent, inputs_done, LongWordBytes + 8);
      $display("checked %0d tokens (%0d keywords), %0d mismatches, %0d left over",
               tokens_checked, keywords_seen, mismatch_count, expected_tokens.size());
      if (mismatch_count == 0 && expected_tokens.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
